@@ sv/fbfse_pkg.sv @@
`default_nettype none

package fbfse_pkg;

   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 32;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_ENABLE        = 3'd0,
      CSR_ACTIVE_WIDTH  = 3'd1,
      CSR_ACTIVE_HEIGHT = 3'd2,
      CSR_RED_SHIFT     = 3'd3,
      CSR_GREEN_SHIFT   = 3'd4,
      CSR_BLUE_SHIFT    = 3'd5
   } csr_index_type;

   typedef enum logic [1:0] {
      KIND_FILL   = 2'd0,
      KIND_SCROLL = 2'd1,
      KIND_READ   = 2'd2,
      KIND_PACK   = 2'd3
   } kind_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_WALK,
      ST_READ,
      ST_FINISH
   } state_type;

   typedef struct packed {
      logic       enable;
      logic [8:0] active_width;
      logic [8:0] active_height;
      logic [4:0] red_shift;
      logic [4:0] green_shift;
      logic [4:0] blue_shift;
   } cfg_type;

   localparam cfg_type CFG_RESET = '{
      enable:        1'b0,
      active_width:  9'd256,
      active_height: 9'd256,
      red_shift:     5'd16,
      green_shift:   5'd8,
      blue_shift:    5'd0
   };

   typedef struct packed {
      logic load;
      logic walk;
      logic read;
      logic out_load;
   } cmd_type;

   typedef struct packed {
      logic walk;
      logic read;
      logic walk_done;
   } sts_type;

endpackage

`default_nettype wire

@@ sv/framebuffer_fill_scroll_engine_core.sv @@
`default_nettype none

// Rectangle fill and scroll engine over a MAX_WIDTH by MAX_HEIGHT store of 32-bit pixels.
// The block works on one item at a time, and every item gives exactly one result item.
// The walk over the pixel memory, one read and one write port, sets the rate: a fill writes
// one pixel per cycle, and a scroll that moves rows copies one pixel per cycle, waits for
// the write of its last copied pixel, then fills the vacated rows one pixel per cycle. Fill
// and scroll items go through the walk state, read items through the read state, and pack
// and ignored items go straight to the finish state. The next item is
// accepted while the previous result still waits on rsp_stall. The pixel store is not
// cleared by reset, so a pixel must be written by a fill or scroll before it is read.
// Configuration writes are always accepted and should only be issued while the block is idle.

module framebuffer_fill_scroll_engine_core #(
   parameter int MAX_WIDTH  = 256,
   parameter int MAX_HEIGHT = 256
) (
   input  wire                                clock,
   input  wire                                reset,
   input  wire                                req_valid,
   output logic                               req_stall,
   input  wire  [1:0]                         req_kind,
   input  wire  [15:0]                        req_origin_x,
   input  wire  [15:0]                        req_origin_y,
   input  wire  [15:0]                        req_rect_width,
   input  wire  [15:0]                        req_rect_height,
   input  wire  [15:0]                        req_scroll_rows,
   input  wire  [31:0]                        req_color,
   input  wire  [7:0]                         req_red,
   input  wire  [7:0]                         req_green,
   input  wire  [7:0]                         req_blue,
   output logic                               rsp_valid,
   input  wire                                rsp_stall,
   output logic [31:0]                        rsp_result_word,
   output logic                               rsp_status,
   input  wire                                csr_valid,
   output logic                               csr_ready,
   input  wire  [fbfse_pkg::CSR_INDEX_W-1:0]  csr_index,
   input  wire  [fbfse_pkg::CSR_DATA_W-1:0]   csr_wdata
);

   fbfse_pkg::cfg_type cfg;
   fbfse_pkg::cmd_type cmd;
   fbfse_pkg::sts_type sts;

   fbfse_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   fbfse_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .sts       (sts),
      .cmd       (cmd)
   );

   fbfse_dp #(
      .MAX_WIDTH  (MAX_WIDTH),
      .MAX_HEIGHT (MAX_HEIGHT)
   ) u_dp (
      .clock           (clock),
      .reset           (reset),
      .cfg             (cfg),
      .cmd             (cmd),
      .sts             (sts),
      .req_kind        (req_kind),
      .req_origin_x    (req_origin_x),
      .req_origin_y    (req_origin_y),
      .req_rect_width  (req_rect_width),
      .req_rect_height (req_rect_height),
      .req_scroll_rows (req_scroll_rows),
      .req_color       (req_color),
      .req_red         (req_red),
      .req_green       (req_green),
      .req_blue        (req_blue),
      .rsp_result_word (rsp_result_word),
      .rsp_status      (rsp_status)
   );

   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> req_stall)
      else $error("block did not go busy after accepting an item");

   a_no_result_overwrite: assert property (@(posedge clock) disable iff (reset)
      cmd.out_load |-> (!rsp_valid || !rsp_stall))
      else $error("result register loaded while a result was still held");

   a_one_command: assert property (@(posedge clock) disable iff (reset)
      $onehot0({cmd.load, cmd.walk, cmd.read, cmd.out_load}))
      else $error("controller issued more than one command");

endmodule

`default_nettype wire

@@ sv/fbfse_csr.sv @@
`default_nettype none

module fbfse_csr (
   input  wire                                   clock,
   input  wire                                   reset,
   input  wire                                   csr_valid,
   output logic                                  csr_ready,
   input  wire  [fbfse_pkg::CSR_INDEX_W-1:0]     csr_index,
   input  wire  [fbfse_pkg::CSR_DATA_W-1:0]      csr_wdata,
   output fbfse_pkg::cfg_type                    cfg
);

   fbfse_pkg::cfg_type cfg_ff;
   fbfse_pkg::cfg_type cfg_in;

   assign csr_ready = 1'b1;
   assign cfg       = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid && csr_ready) begin
         case (fbfse_pkg::csr_index_type'(csr_index))
            fbfse_pkg::CSR_ENABLE:        cfg_in.enable        = csr_wdata[0];
            fbfse_pkg::CSR_ACTIVE_WIDTH:  cfg_in.active_width  = csr_wdata[8:0];
            fbfse_pkg::CSR_ACTIVE_HEIGHT: cfg_in.active_height = csr_wdata[8:0];
            fbfse_pkg::CSR_RED_SHIFT:     cfg_in.red_shift     = csr_wdata[4:0];
            fbfse_pkg::CSR_GREEN_SHIFT:   cfg_in.green_shift   = csr_wdata[4:0];
            fbfse_pkg::CSR_BLUE_SHIFT:    cfg_in.blue_shift    = csr_wdata[4:0];
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= fbfse_pkg::CFG_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

`default_nettype wire

@@ sv/fbfse_ctrl.sv @@
`default_nettype none

module fbfse_ctrl (
   input  wire                  clock,
   input  wire                  reset,
   input  wire                  req_valid,
   output logic                 req_stall,
   output logic                 rsp_valid,
   input  wire                  rsp_stall,
   input  fbfse_pkg::sts_type   sts,
   output fbfse_pkg::cmd_type   cmd
);

   fbfse_pkg::state_type state_ff;
   fbfse_pkg::state_type state_in;
   logic                 rsp_valid_ff;
   logic                 rsp_valid_in;
   logic                 out_free;

   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         fbfse_pkg::ST_IDLE: begin
            if (req_valid) begin
               if (sts.walk) begin
                  state_in = fbfse_pkg::ST_WALK;
               end else if (sts.read) begin
                  state_in = fbfse_pkg::ST_READ;
               end else begin
                  state_in = fbfse_pkg::ST_FINISH;
               end
            end
         end
         fbfse_pkg::ST_WALK: begin
            if (sts.walk_done) begin
               state_in = fbfse_pkg::ST_FINISH;
            end
         end
         fbfse_pkg::ST_READ: begin
            state_in = fbfse_pkg::ST_FINISH;
         end
         fbfse_pkg::ST_FINISH: begin
            if (out_free) begin
               state_in = fbfse_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = fbfse_pkg::ST_IDLE;
         end
      endcase
   end

   always_comb begin
      cmd          = '0;
      req_stall    = 1'b1;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      case (state_ff)
         fbfse_pkg::ST_IDLE: begin
            req_stall = 1'b0;
            cmd.load  = req_valid;
         end
         fbfse_pkg::ST_WALK: begin
            cmd.walk = 1'b1;
         end
         fbfse_pkg::ST_READ: begin
            cmd.read = 1'b1;
         end
         fbfse_pkg::ST_FINISH: begin
            if (out_free) begin
               cmd.out_load = 1'b1;
               rsp_valid_in = 1'b1;
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= fbfse_pkg::ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

`default_nettype wire

@@ sv/fbfse_dp.sv @@
`default_nettype none

module fbfse_dp #(
   parameter int MAX_WIDTH  = 256,
   parameter int MAX_HEIGHT = 256
) (
   input  wire                  clock,
   input  wire                  reset,
   input  fbfse_pkg::cfg_type   cfg,
   input  fbfse_pkg::cmd_type   cmd,
   output fbfse_pkg::sts_type   sts,
   input  wire  [1:0]           req_kind,
   input  wire  [15:0]          req_origin_x,
   input  wire  [15:0]          req_origin_y,
   input  wire  [15:0]          req_rect_width,
   input  wire  [15:0]          req_rect_height,
   input  wire  [15:0]          req_scroll_rows,
   input  wire  [31:0]          req_color,
   input  wire  [7:0]           req_red,
   input  wire  [7:0]           req_green,
   input  wire  [7:0]           req_blue,
   output logic [31:0]          rsp_result_word,
   output logic                 rsp_status
);

   localparam int CW    = $clog2(MAX_WIDTH + 1);
   localparam int RW    = $clog2(MAX_HEIGHT + 1);
   localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT;
   localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam logic [16:0] MAX_W17 = 17'(MAX_WIDTH);
   localparam logic [16:0] MAX_H17 = 17'(MAX_HEIGHT);

   logic [31:0] pixel_mem [DEPTH];

   fbfse_pkg::kind_type kind;
   logic [16:0] aw17;
   logic [16:0] ah17;
   logic [16:0] ex17;
   logic [16:0] ey17;
   logic [16:0] rows17;
   logic        in_area;
   logic        ignored;
   logic [31:0] packed_word;

   logic [CW-1:0] col_ff, col_in;
   logic [CW-1:0] col_start_ff, col_start_in;
   logic [CW-1:0] col_end_ff, col_end_in;
   logic [RW-1:0] row_ff, row_in;
   logic [RW-1:0] copy_end_ff, copy_end_in;
   logic [RW-1:0] fill_end_ff, fill_end_in;
   logic [RW-1:0] off_ff, off_in;
   logic [31:0]   color_ff, color_in;
   logic [31:0]   res_word_ff, res_word_in;
   logic          res_status_ff, res_status_in;
   logic          use_rdata_ff, use_rdata_in;
   logic          pend_ff, pend_in;
   logic [AW-1:0] pend_addr_ff, pend_addr_in;
   logic [31:0]   rdata_ff;
   logic [31:0]   rsp_result_word_ff, rsp_result_word_in;
   logic          rsp_status_ff, rsp_status_in;

   logic          cols_nonempty;
   logic          copy_act;
   logic          fill_act;
   logic          copy_step;
   logic          fill_step;
   logic          col_last;
   logic [RW-1:0] src_row;
   logic [AW-1:0] dst_addr;
   logic [AW-1:0] src_addr;
   logic [AW-1:0] raddr;
   logic          mem_re;
   logic          mem_we;
   logic [AW-1:0] waddr;
   logic [31:0]   wdata;

   assign kind   = fbfse_pkg::kind_type'(req_kind);
   assign aw17   = (17'(cfg.active_width) > MAX_W17) ? MAX_W17 : 17'(cfg.active_width);
   assign ah17   = (17'(cfg.active_height) > MAX_H17) ? MAX_H17 : 17'(cfg.active_height);
   assign ex17   = 17'(req_origin_x) + 17'(req_rect_width);
   assign ey17   = 17'(req_origin_y) + 17'(req_rect_height);
   assign rows17 = 17'(req_scroll_rows);
   assign in_area = (17'(req_origin_x) < aw17) && (17'(req_origin_y) < ah17);
   assign packed_word = (32'(req_red) << cfg.red_shift)
                      | (32'(req_green) << cfg.green_shift)
                      | (32'(req_blue) << cfg.blue_shift);

   always_comb begin
      ignored = 1'b1;
      if (cfg.enable) begin
         case (kind)
            fbfse_pkg::KIND_FILL:   ignored = !in_area;
            fbfse_pkg::KIND_SCROLL: ignored = (req_scroll_rows == 16'd0);
            fbfse_pkg::KIND_READ:   ignored = !in_area;
            fbfse_pkg::KIND_PACK:   ignored = 1'b0;
            default:                ignored = 1'b1;
         endcase
      end
   end

   assign sts.walk = !ignored && ((kind == fbfse_pkg::KIND_FILL)
                               || (kind == fbfse_pkg::KIND_SCROLL));
   assign sts.read = !ignored && (kind == fbfse_pkg::KIND_READ);

   assign cols_nonempty = col_start_ff < col_end_ff;
   assign copy_act      = (row_ff < copy_end_ff) && cols_nonempty;
   assign fill_act      = (row_ff < fill_end_ff) && cols_nonempty;
   assign copy_step     = cmd.walk && copy_act;
   assign fill_step     = cmd.walk && !copy_act && fill_act && !pend_ff;
   assign col_last      = (col_ff + CW'(1)) == col_end_ff;
   assign sts.walk_done = !copy_act && !fill_act && !pend_ff;

   assign src_row  = row_ff + off_ff;
   assign dst_addr = AW'(row_ff) * AW'(MAX_WIDTH) + AW'(col_ff);
   assign src_addr = AW'(src_row) * AW'(MAX_WIDTH) + AW'(col_ff);
   assign raddr    = cmd.read ? dst_addr : src_addr;
   assign mem_re   = cmd.read || copy_step;
   assign mem_we   = pend_ff || fill_step;
   assign waddr    = pend_ff ? pend_addr_ff : dst_addr;
   assign wdata    = pend_ff ? rdata_ff : color_ff;

   always_comb begin
      col_in        = col_ff;
      col_start_in  = col_start_ff;
      col_end_in    = col_end_ff;
      row_in        = row_ff;
      copy_end_in   = copy_end_ff;
      fill_end_in   = fill_end_ff;
      off_in        = off_ff;
      color_in      = color_ff;
      res_word_in   = res_word_ff;
      res_status_in = res_status_ff;
      use_rdata_in  = use_rdata_ff;
      if (cmd.load) begin
         color_in      = req_color;
         res_status_in = ignored;
         res_word_in   = (!ignored && (kind == fbfse_pkg::KIND_PACK)) ? packed_word : 32'd0;
         use_rdata_in  = sts.read;
         off_in        = RW'(req_scroll_rows);
         if (kind == fbfse_pkg::KIND_SCROLL) begin
            col_start_in = '0;
            col_in       = '0;
            col_end_in   = CW'(aw17);
            row_in       = '0;
            copy_end_in  = (rows17 >= ah17) ? '0 : RW'(ah17 - rows17);
            fill_end_in  = RW'(ah17);
         end else begin
            col_start_in = CW'(req_origin_x);
            col_in       = CW'(req_origin_x);
            col_end_in   = (ex17 > aw17) ? CW'(aw17) : CW'(ex17);
            row_in       = RW'(req_origin_y);
            copy_end_in  = '0;
            fill_end_in  = (ey17 > ah17) ? RW'(ah17) : RW'(ey17);
         end
      end else if (copy_step || fill_step) begin
         if (col_last) begin
            col_in = col_start_ff;
            row_in = row_ff + RW'(1);
         end else begin
            col_in = col_ff + CW'(1);
         end
      end
   end

   assign pend_in      = copy_step;
   assign pend_addr_in = dst_addr;

   always_comb begin
      rsp_result_word_in = rsp_result_word_ff;
      rsp_status_in      = rsp_status_ff;
      if (cmd.out_load) begin
         rsp_result_word_in = use_rdata_ff ? rdata_ff : res_word_ff;
         rsp_status_in      = res_status_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         pixel_mem[waddr] <= wdata;
      end
      if (mem_re) begin
         rdata_ff <= pixel_mem[raddr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pend_ff <= 1'b0;
      end else begin
         pend_ff <= pend_in;
      end
   end

   always_ff @(posedge clock) begin
      col_ff             <= col_in;
      col_start_ff       <= col_start_in;
      col_end_ff         <= col_end_in;
      row_ff             <= row_in;
      copy_end_ff        <= copy_end_in;
      fill_end_ff        <= fill_end_in;
      off_ff             <= off_in;
      color_ff           <= color_in;
      res_word_ff        <= res_word_in;
      res_status_ff      <= res_status_in;
      use_rdata_ff       <= use_rdata_in;
      pend_addr_ff       <= pend_addr_in;
      rsp_result_word_ff <= rsp_result_word_in;
      rsp_status_ff      <= rsp_status_in;
   end

   assign rsp_result_word = rsp_result_word_ff;
   assign rsp_status      = rsp_status_ff;

endmodule

`default_nettype wire

@@ sim/testbench.sv @@
`default_nettype none

module testbench;

   localparam int unsigned STORE_W = 256;
   localparam int unsigned STORE_H = 256;
   localparam int unsigned WATCHDOG_LIMIT = 270000;
   localparam int unsigned LONG_HOLD = 300;
   localparam int unsigned SETTLE_CYCLES = 8;

   typedef struct {
      fbfse_pkg::kind_type kind;
      logic [15:0] origin_x;
      logic [15:0] origin_y;
      logic [15:0] rect_width;
      logic [15:0] rect_height;
      logic [15:0] scroll_rows;
      logic [31:0] color;
      logic [7:0]  red;
      logic [7:0]  green;
      logic [7:0]  blue;
   } draw_cmd_type;

   typedef struct {
      logic [31:0] word;
      logic        status;
   } draw_reply_type;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_valid = 1'b0;
   logic                  req_stall;
   fbfse_pkg::kind_type   req_kind = fbfse_pkg::KIND_FILL;
   logic [15:0]           req_origin_x = '0;
   logic [15:0]           req_origin_y = '0;
   logic [15:0]           req_rect_width = '0;
   logic [15:0]           req_rect_height = '0;
   logic [15:0]           req_scroll_rows = '0;
   logic [31:0]           req_color = '0;
   logic [7:0]            req_red = '0;
   logic [7:0]            req_green = '0;
   logic [7:0]            req_blue = '0;
   logic                  rsp_valid;
   logic                  rsp_stall = 1'b0;
   logic [31:0]           rsp_result_word;
   logic                  rsp_status;
   logic                  csr_valid = 1'b0;
   logic                  csr_ready;
   fbfse_pkg::csr_index_type csr_index = fbfse_pkg::CSR_ENABLE;
   logic [fbfse_pkg::CSR_DATA_W-1:0] csr_wdata = '0;

   fbfse_pkg::cfg_type shadow_cfg = fbfse_pkg::CFG_RESET;
   logic [31:0]    frame_pixels [0:STORE_W*STORE_H-1];
   draw_reply_type expected_replies [$];

   bit          gaps_on = 1'b1;
   int unsigned hold_request = 0;
   int unsigned stall_left = 0;
   int unsigned quiet_cycles = 0;
   int unsigned input_held_cycles = 0;
   int unsigned items_sent = 0;
   int unsigned replies_checked = 0;
   int unsigned setting_count = 0;
   int unsigned error_count = 0;

   framebuffer_fill_scroll_engine_core #(
      .MAX_WIDTH(STORE_W),
      .MAX_HEIGHT(STORE_H)
   ) u_top (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_kind(req_kind),
      .req_origin_x(req_origin_x),
      .req_origin_y(req_origin_y),
      .req_rect_width(req_rect_width),
      .req_rect_height(req_rect_height),
      .req_scroll_rows(req_scroll_rows),
      .req_color(req_color),
      .req_red(req_red),
      .req_green(req_green),
      .req_blue(req_blue),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_result_word(rsp_result_word),
      .rsp_status(rsp_status),
      .csr_valid(csr_valid),
      .csr_ready(csr_ready),
      .csr_index(csr_index),
      .csr_wdata(csr_wdata)
   );

   always #5 clock = ~clock;

   function automatic int unsigned area_width();
      return (shadow_cfg.active_width > STORE_W) ? STORE_W : 32'(shadow_cfg.active_width);
   endfunction

   function automatic int unsigned area_height();
      return (shadow_cfg.active_height > STORE_H) ? STORE_H : 32'(shadow_cfg.active_height);
   endfunction

   function automatic void paint_rect(int unsigned x, int unsigned y, longint unsigned w,
                                      longint unsigned h, logic [31:0] color);
      longint unsigned x_end;
      longint unsigned y_end;
      int unsigned     r;
      int unsigned     col;
      x_end = x + w;
      y_end = y + h;
      if (x_end > area_width()) x_end = area_width();
      if (y_end > area_height()) y_end = area_height();
      for (r = y; r < y_end; r++)
         for (col = x; col < x_end; col++)
            frame_pixels[r*STORE_W + col] = color;
   endfunction

   // Updates the pixel store copy and returns the result the block must give.
   function automatic draw_reply_type predict_reply(draw_cmd_type c);
      draw_reply_type rep;
      int unsigned aw;
      int unsigned ah;
      int unsigned keep;
      int unsigned r;
      int unsigned col;
      aw = area_width();
      ah = area_height();
      rep.word = '0;
      rep.status = 1'b1;
      if (shadow_cfg.enable) begin
         case (c.kind)
            fbfse_pkg::KIND_FILL: begin
               if (c.origin_x < aw && c.origin_y < ah) begin
                  paint_rect(32'(c.origin_x), 32'(c.origin_y), 64'(c.rect_width),
                             64'(c.rect_height), c.color);
                  rep.status = 1'b0;
               end
            end
            fbfse_pkg::KIND_SCROLL: begin
               if (c.scroll_rows != 0) begin
                  if (c.scroll_rows >= ah) begin
                     paint_rect(0, 0, 64'(aw), 64'(ah), c.color);
                  end else begin
                     keep = ah - 32'(c.scroll_rows);
                     for (r = 0; r < keep; r++)
                        for (col = 0; col < aw; col++)
                           frame_pixels[r*STORE_W + col] =
                              frame_pixels[(r + c.scroll_rows)*STORE_W + col];
                     paint_rect(0, keep, 64'(aw), 64'(c.scroll_rows), c.color);
                  end
                  rep.status = 1'b0;
               end
            end
            fbfse_pkg::KIND_READ: begin
               if (c.origin_x < aw && c.origin_y < ah) begin
                  rep.word = frame_pixels[c.origin_y*STORE_W + c.origin_x];
                  rep.status = 1'b0;
               end
            end
            default: begin
               rep.word = (32'(c.red) << shadow_cfg.red_shift)
                        | (32'(c.green) << shadow_cfg.green_shift)
                        | (32'(c.blue) << shadow_cfg.blue_shift);
               rep.status = 1'b0;
            end
         endcase
      end
      return rep;
   endfunction

   function automatic draw_cmd_type make_cmd(fbfse_pkg::kind_type k, int unsigned x,
                                             int unsigned y, int unsigned w,
                                             int unsigned h, int unsigned rows,
                                             logic [31:0] color);
      draw_cmd_type c;
      c.kind = k;
      c.origin_x = 16'(x);
      c.origin_y = 16'(y);
      c.rect_width = 16'(w);
      c.rect_height = 16'(h);
      c.scroll_rows = 16'(rows);
      c.color = color;
      c.red = color[23:16];
      c.green = color[15:8];
      c.blue = color[7:0];
      return c;
   endfunction

   // Mostly well-formed commands inside the active area, with some raw field values mixed in.
   function automatic draw_cmd_type random_cmd();
      draw_cmd_type c;
      int unsigned  aw;
      int unsigned  ah;
      int unsigned  pick;
      aw = area_width();
      ah = area_height();
      pick = $urandom_range(0, 9);
      c.kind = (pick < 3) ? fbfse_pkg::KIND_FILL : (pick < 5) ? fbfse_pkg::KIND_SCROLL :
               (pick < 8) ? fbfse_pkg::KIND_READ : fbfse_pkg::KIND_PACK;
      if ($urandom_range(0, 99) < 85) begin
         c.origin_x = 16'($urandom_range(0, aw - 1));
         c.origin_y = 16'($urandom_range(0, ah - 1));
      end else begin
         c.origin_x = 16'($urandom());
         c.origin_y = 16'($urandom());
      end
      if ($urandom_range(0, 99) < 70) begin
         c.rect_width = 16'($urandom_range(0, aw));
         c.rect_height = 16'($urandom_range(0, ah));
      end else begin
         c.rect_width = 16'($urandom());
         c.rect_height = 16'($urandom());
      end
      pick = $urandom_range(0, 9);
      if (pick < 7) begin
         c.scroll_rows = 16'($urandom_range(1, ah));
      end else if (pick < 8) begin
         c.scroll_rows = '0;
      end else begin
         c.scroll_rows = 16'($urandom());
      end
      c.color = $urandom();
      c.red = 8'($urandom());
      c.green = 8'($urandom());
      c.blue = 8'($urandom());
      return c;
   endfunction

   function automatic int unsigned pick_gap();
      int unsigned roll;
      if (!gaps_on) return 0;
      roll = $urandom_range(0, 99);
      if (roll < 60) return 0;
      if (roll < 92) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   task automatic issue_cmd(input draw_cmd_type c);
      int unsigned gap;
      gap = pick_gap();
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_kind <= c.kind;
      req_origin_x <= c.origin_x;
      req_origin_y <= c.origin_y;
      req_rect_width <= c.rect_width;
      req_rect_height <= c.rect_height;
      req_scroll_rows <= c.scroll_rows;
      req_color <= c.color;
      req_red <= c.red;
      req_green <= c.green;
      req_blue <= c.blue;
      req_valid <= 1'b1;
      do @(posedge clock); while (req_stall);
      expected_replies.push_back(predict_reply(c));
      items_sent++;
   endtask

   task automatic drain_results();
      req_valid <= 1'b0;
      @(posedge clock);
      while (expected_replies.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_reg(input fbfse_pkg::csr_index_type idx, input logic [31:0] data);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      do @(posedge clock); while (!csr_ready);
      case (idx)
         fbfse_pkg::CSR_ENABLE: shadow_cfg.enable = data[0];
         fbfse_pkg::CSR_ACTIVE_WIDTH: shadow_cfg.active_width = data[8:0];
         fbfse_pkg::CSR_ACTIVE_HEIGHT: shadow_cfg.active_height = data[8:0];
         fbfse_pkg::CSR_RED_SHIFT: shadow_cfg.red_shift = data[4:0];
         fbfse_pkg::CSR_GREEN_SHIFT: shadow_cfg.green_shift = data[4:0];
         fbfse_pkg::CSR_BLUE_SHIFT: shadow_cfg.blue_shift = data[4:0];
         default: ;
      endcase
   endtask

   task automatic configure(input logic en, input int unsigned w, input int unsigned h,
                            input int unsigned rs, input int unsigned gs,
                            input int unsigned bs);
      drain_results();
      write_reg(fbfse_pkg::CSR_ENABLE, 32'(en));
      write_reg(fbfse_pkg::CSR_ACTIVE_WIDTH, w);
      write_reg(fbfse_pkg::CSR_ACTIVE_HEIGHT, h);
      write_reg(fbfse_pkg::CSR_RED_SHIFT, rs);
      write_reg(fbfse_pkg::CSR_GREEN_SHIFT, gs);
      write_reg(fbfse_pkg::CSR_BLUE_SHIFT, bs);
      csr_valid <= 1'b0;
      @(posedge clock);
      setting_count++;
   endtask

   task automatic run_random(input int unsigned count);
      repeat (count) issue_cmd(random_cmd());
   endtask

   task automatic test_disabled_commands();
      issue_cmd(make_cmd(fbfse_pkg::KIND_FILL, 0, 0, 1, 1, 0, 32'h1234_5678));
      issue_cmd(make_cmd(fbfse_pkg::KIND_SCROLL, 0, 0, 0, 0, 1, 32'h0BAD_F00D));
      issue_cmd(make_cmd(fbfse_pkg::KIND_READ, 0, 0, 0, 0, 0, 32'h0));
      issue_cmd(make_cmd(fbfse_pkg::KIND_PACK, 0, 0, 0, 0, 0, 32'h00FF_FFFF));
   endtask

   // Writes every pixel of the store so that any later read is defined.
   task automatic test_store_clear();
      configure(1'b1, 256, 256, 16, 8, 0);
      issue_cmd(make_cmd(fbfse_pkg::KIND_FILL, 0, 0, 65535, 65535, 0, 32'hC0DE_5A5A));
      issue_cmd(make_cmd(fbfse_pkg::KIND_READ, 0, 0, 0, 0, 0, 32'h0));
      issue_cmd(make_cmd(fbfse_pkg::KIND_READ, 255, 255, 0, 0, 0, 32'h0));
      issue_cmd(make_cmd(fbfse_pkg::KIND_PACK, 0, 0, 0, 0, 0, 32'h00A5_3C81));
   endtask

   task automatic test_edge_cases();
      configure(1'b1, 8, 6, 16, 8, 0);
      issue_cmd(make_cmd(fbfse_pkg::KIND_FILL, 2, 1, 3, 2, 0, 32'hFFFF_FFFF));
      issue_cmd(make_cmd(fbfse_pkg::KIND_FILL, 8, 0, 1, 1, 0, 32'h1111_1111));
      issue_cmd(make_cmd(fbfse_pkg::KIND_FILL, 65535, 65535, 1, 1, 0, 32'h2222_2222));
      issue_cmd(make_cmd(fbfse_pkg::KIND_FILL, 7, 5, 65535, 65535, 0, 32'h3333_3333));
      issue_cmd(make_cmd(fbfse_pkg::KIND_FILL, 0, 0, 0, 5, 0, 32'h4444_4444));
      issue_cmd(make_cmd(fbfse_pkg::KIND_READ, 2, 1, 0, 0, 0, 32'h0));
      issue_cmd(make_cmd(fbfse_pkg::KIND_READ, 8, 0, 0, 0, 0, 32'h0));
      issue_cmd(make_cmd(fbfse_pkg::KIND_SCROLL, 0, 0, 0, 0, 0, 32'h5555_5555));
      issue_cmd(make_cmd(fbfse_pkg::KIND_SCROLL, 0, 0, 0, 0, 1, 32'h6666_6666));
      issue_cmd(make_cmd(fbfse_pkg::KIND_READ, 2, 0, 0, 0, 0, 32'h0));
      issue_cmd(make_cmd(fbfse_pkg::KIND_SCROLL, 0, 0, 0, 0, 6, 32'h7777_7777));
      issue_cmd(make_cmd(fbfse_pkg::KIND_SCROLL, 0, 0, 0, 0, 65535, 32'h0000_0000));
      issue_cmd(make_cmd(fbfse_pkg::KIND_READ, 0, 5, 0, 0, 0, 32'h0));
      configure(1'b1, 8, 6, 31, 24, 0);
      issue_cmd(make_cmd(fbfse_pkg::KIND_PACK, 0, 0, 0, 0, 0, 32'h00FF_FFFF));
   endtask

   task automatic test_zero_area();
      configure(1'b1, 0, 4, 16, 8, 0);
      issue_cmd(make_cmd(fbfse_pkg::KIND_FILL, 0, 0, 4, 4, 0, 32'h8888_8888));
      issue_cmd(make_cmd(fbfse_pkg::KIND_READ, 0, 0, 0, 0, 0, 32'h0));
      issue_cmd(make_cmd(fbfse_pkg::KIND_SCROLL, 0, 0, 0, 0, 1, 32'h9999_9999));
      configure(1'b1, 4, 0, 16, 8, 0);
      issue_cmd(make_cmd(fbfse_pkg::KIND_SCROLL, 0, 0, 0, 0, 2, 32'hAAAA_AAAA));
      issue_cmd(make_cmd(fbfse_pkg::KIND_READ, 0, 0, 0, 0, 0, 32'h0));
   endtask

   task automatic test_oversize_area();
      configure(1'b1, 511, 300, 0, 0, 0);
      issue_cmd(make_cmd(fbfse_pkg::KIND_SCROLL, 0, 0, 0, 0, 3, 32'hBBBB_BBBB));
      issue_cmd(make_cmd(fbfse_pkg::KIND_FILL, 250, 250, 65535, 65535, 0, 32'hDDDD_DDDD));
      issue_cmd(make_cmd(fbfse_pkg::KIND_FILL, 256, 0, 1, 1, 0, 32'hEEEE_EEEE));
      issue_cmd(make_cmd(fbfse_pkg::KIND_READ, 255, 255, 0, 0, 0, 32'h0));
      issue_cmd(make_cmd(fbfse_pkg::KIND_READ, 0, 0, 0, 0, 0, 32'h0));
   endtask

   task automatic test_random_traffic();
      configure(1'b1, 1, 1, 0, 0, 0);
      run_random(10);
      configure(1'b1, 16, 16, $urandom_range(0, 31), $urandom_range(0, 31),
                $urandom_range(0, 31));
      run_random(11);
      configure(1'b1, $urandom_range(1, 16), $urandom_range(1, 16),
                $urandom_range(0, 31), $urandom_range(0, 31), $urandom_range(0, 31));
      gaps_on = 1'b0;
      run_random(10);
      gaps_on = 1'b1;
      configure(1'b0, 16, 16, 16, 8, 0);
      run_random(4);
      configure(1'b1, 12, 3, 24, 24, 24);
      run_random(10);
      configure(1'b1, 256, 2, $urandom_range(0, 31), $urandom_range(0, 31),
                $urandom_range(0, 31));
      run_random(11);
   endtask

   // The receiver holds off long enough for the block to stall its input, then the
   // sender stops until every result is back before going on.
   task automatic test_backpressure();
      configure(1'b1, 16, 16, 16, 8, 0);
      gaps_on = 1'b0;
      hold_request = LONG_HOLD;
      run_random(12);
      drain_results();
      run_random(8);
      gaps_on = 1'b1;
   endtask

   always @(posedge clock) begin : reply_check
      draw_reply_type want;
      if (!reset && rsp_valid === 1'b1 && !rsp_stall) begin
         replies_checked++;
         if (expected_replies.size() == 0) begin
            $display("%0t: result with nothing expected: word %h status %b",
                     $time, rsp_result_word, rsp_status);
            error_count++;
         end else begin
            want = expected_replies.pop_front();
            if (rsp_result_word !== want.word) begin
               $display("%0t: result_word mismatch: expected %h, actual %h",
                        $time, want.word, rsp_result_word);
               error_count++;
            end
            if (rsp_status !== want.status) begin
               $display("%0t: status mismatch: expected %b, actual %b",
                        $time, want.status, rsp_status);
               error_count++;
            end
         end
      end
      if (hold_request != 0) begin
         stall_left = hold_request;
         hold_request = 0;
      end
      if (stall_left != 0) begin
         rsp_stall <= 1'b1;
         stall_left--;
      end else if (gaps_on && $urandom_range(0, 99) < 20) begin
         stall_left = ($urandom_range(0, 9) < 8) ? $urandom_range(0, 2) : $urandom_range(9, 49);
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= 1'b0;
      end
   end

   always @(posedge clock) begin
      if (req_valid && req_stall === 1'b1) input_held_cycles++;
      if ((req_valid && req_stall === 1'b0) || (rsp_valid === 1'b1 && !rsp_stall) ||
          (csr_valid && csr_ready === 1'b1)) begin
         quiet_cycles = 0;
      end else begin
         quiet_cycles++;
      end
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("%0t: no handshake for %0d cycles", $time, quiet_cycles);
         $display("tb: failure");
         $finish;
      end
   end

   initial begin
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_disabled_commands();
      test_store_clear();
      test_edge_cases();
      test_zero_area();
      test_oversize_area();
      test_random_traffic();
      test_backpressure();
      drain_results();
      repeat (20) @(posedge clock);
      $display("tb: %0d items sent, %0d results checked over %0d register settings",
               items_sent, replies_checked, setting_count);
      $display("tb: input held off for %0d cycles, %0d mismatches",
               input_held_cycles, error_count);
      if (error_count == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

endmodule

`default_nettype wire
